// ----- hw/rtl/givens_qr_matrix_inverse_defines.svh -----
// Assertion shorthands for the Givens inverse block.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef GIVENS_QR_MATRIX_INVERSE_DEFINES_SVH
`define GIVENS_QR_MATRIX_INVERSE_DEFINES_SVH

// Same-cycle implication.
`define GQI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gqi check failed");

// Next-cycle implication.
`define GQI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gqi check failed");

`endif

// ----- hw/rtl/gqi_pkg.sv -----
`default_nettype none
package gqi_pkg;

  localparam int WORD_W     = 32;
  localparam int SIZE_W     = 4;
  localparam int ROT_BITS   = 30;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic REG_MATRIX_SIZE = 1'b0;

  localparam logic signed [31:0] ROT_ONE = 32'sh40000000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [0:0] {
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [5:0] {
    ST_LOAD,
    ST_QINIT,
    ST_PV_RDX,
    ST_PV_RDY,
    ST_PV_LATY,
    ST_PV_SQ1,
    ST_PV_SQ2,
    ST_PV_SQ3,
    ST_PV_SQRT_GO,
    ST_PV_SQRT_WAIT,
    ST_PV_COS_GO,
    ST_PV_COS_WAIT,
    ST_PV_SIN_GO,
    ST_PV_SIN_WAIT,
    ST_PV_WRK,
    ST_PV_WRL,
    ST_RT_RDA,
    ST_RT_RDB,
    ST_RT_M1,
    ST_RT_M2,
    ST_RT_M3,
    ST_RT_M4,
    ST_RT_M5,
    ST_RT_M6,
    ST_BS_RDQ,
    ST_BS_RDD,
    ST_BS_LATD,
    ST_BS_RDL,
    ST_BS_MUL,
    ST_BS_ACC,
    ST_BS_DIV_GO,
    ST_BS_DIV_WAIT,
    ST_EMIT
  } state_t;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : 32'(a);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Drop ROT_BITS fraction bits, round half away from zero, clip to a word.
  function automatic logic signed [31:0] rnd_sat30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [33:0] t;
    mag = v[63] ? 64'(-v) : 64'(v);
    t   = 34'((mag + (64'd1 << (ROT_BITS - 1))) >> ROT_BITS);
    if (!v[63]) begin
      return (t > 34'h07FFFFFFF) ? S32_MAX : 32'(t);
    end
    return (t > 34'h080000000) ? S32_MIN : 32'(34'(-t));
  endfunction

  // a - b, clipped to the 64-bit range.
  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Signed quotient from magnitude and sign, clipped to a word: {clip, value}.
  function automatic logic [32:0] sat_quo(input logic [63:0] mag, input logic neg);
    logic clip;
    if (!neg) begin
      clip = |mag[63:31];
      return {clip, clip ? S32_MAX : mag[31:0]};
    end
    clip = (|mag[63:32]) || (mag[31] && (|mag[30:0]));
    return {clip, clip ? S32_MIN : 32'(-mag[31:0])};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gqi_ram.sv -----
`default_nettype none
module gqi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gqi_divsqrt.sv -----
`default_nettype none
// Bit-serial unit: unsigned 64/32 restoring divide (one quotient bit a cycle)
// or 64-bit integer square root (one root bit a cycle).
module gqi_divsqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gqi_pkg::unit_req_t req,
  input  wire logic [63:0]        num,
  input  wire logic [31:0]        den,
  output gqi_pkg::unit_stat_t     stat,
  output logic      [63:0]        result
);

  logic              busy;
  logic              done;
  gqi_pkg::unit_op_t op;
  logic [5:0]        cnt;
  logic [63:0]       quo;
  logic [34:0]       rem;
  logic [31:0]       root;
  logic [31:0]       dv;

  logic [34:0] shifted;
  logic [34:0] sub;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    if (op == gqi_pkg::OP_SQRT) begin
      shifted = {rem[32:0], quo[63:62]};
      sub     = {1'b0, root, 2'b01};
    end else begin
      shifted = {rem[33:0], quo[63]};
      sub     = {3'b000, dv};
    end
    diff = {1'b0, shifted} - {1'b0, sub};
    ge   = !diff[35];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      quo  <= num;
      rem  <= '0;
      root <= '0;
      dv   <= den;
      cnt  <= (req.op == gqi_pkg::OP_SQRT) ? 6'(gqi_pkg::SQRT_STEPS - 1)
                                           : 6'(gqi_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      rem <= ge ? diff[34:0] : shifted;
      cnt <= cnt - 6'd1;
      if (op == gqi_pkg::OP_SQRT) begin
        quo  <= {quo[61:0], 2'b00};
        root <= {root[30:0], ge};
      end else begin
        quo <= {quo[62:0], ge};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = (op == gqi_pkg::OP_SQRT) ? {32'b0, root} : quo;

endmodule
`default_nettype wire

// ----- hw/rtl/givens_qr_matrix_inverse.sv -----
`default_nettype none
`include "givens_qr_matrix_inverse_defines.svh"
// Channel   Direction  Handshake                    Word
// element   in         element_valid/element_stall  element_value, element_last
// result    out        result_valid/result_stall    inverse_value, result_last,
//                                                   singular, saturated
// config    in         APB (psel/penable/pready)    matrix_size at byte address 0
//
// Load accepts one word per cycle (n*n words); element_last starts the solve.
// Solve: Q identity fill, then per nonzero pivot pair a square root and two
// divides plus a rotation step per rotated row, then per element of the inverse
// a multiply-accumulate per term and a divide; these share the serial divide/sqrt
// unit and the matrix RAM, which has one read port and one write port.
// Reset is synchronous and returns to load with matrix_size = 8.
// element_stall is high from the last word until the final result word is
// taken; result words hold while result_stall is high.
module givens_qr_matrix_inverse #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               element_valid,
  output logic                    element_stall,
  input  wire logic signed [31:0] element_value,
  input  wire logic               element_last,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed      [31:0] inverse_value,
  output logic                    result_last,
  output logic                    singular,
  output logic                    saturated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int IW    = $clog2(MAX_ORDER);
  localparam int NW    = $clog2(MAX_ORDER + 1);
  localparam int CW    = $clog2(MAX_ORDER * MAX_ORDER + 1);
  localparam int AW    = 2 * IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int SW    = gqi_pkg::SIZE_W;
  localparam logic [31:0] Q_ONE = 32'(64'd1 << FRAC_BITS);

  gqi_pkg::state_t state, state_next;

  // configuration
  logic [SW-1:0] matrix_size;
  logic [NW-1:0] n_cur;
  logic [CW-1:0] nn;

  // sequencer counters; sel picks W (0) or Q (1) in the RAM
  logic [CW-1:0] load_count;
  logic [IW-1:0] nm1, k, l, m, jr, ir;
  logic          sel;

  // datapath registers
  logic signed [31:0] opa, opb, cosr, sinr, dreg;
  logic        [31:0] rr;
  logic signed [63:0] acc, prod;
  logic signed [31:0] xrow [MAX_ORDER];
  logic [MAX_ORDER-1:0] clip;
  logic               singular_seen;

  // RAM and unit hookup
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [31:0]         ram_wdata, ram_rdata;
  gqi_pkg::unit_req_t  ureq;
  gqi_pkg::unit_stat_t ustat;
  logic [63:0]         unum, ures;
  logic [31:0]         uden;

  logic signed [31:0] mul_a, mul_b;
  logic [IW-1:0]      ld_row, ld_col;
  logic               in_acc, out_acc, cfg_wr;
  logic               piv_last, zero_pair;
  logic [32:0]        quo_sat;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == gqi_pkg::REG_MATRIX_SIZE);
  assign prdata = (paddr[2] == gqi_pkg::REG_MATRIX_SIZE) ? 32'(matrix_size) : 32'd0;

  // Clamp order: zero acts as one, oversize acts as MAX_ORDER.
  always_comb begin
    if (matrix_size == '0) begin
      n_cur = NW'(1);
    end else if (matrix_size > SW'(MAX_ORDER)) begin
      n_cur = NW'(MAX_ORDER);
    end else begin
      n_cur = NW'(matrix_size);
    end
    nn = CW'(n_cur) * CW'(n_cur);
  end

  // Row and column of the load position under the current order.
  always_comb begin
    ld_row = '0;
    for (int r = 1; r < MAX_ORDER; r++) begin
      if (load_count >= CW'(r) * CW'(n_cur)) begin
        ld_row = IW'(r);
      end
    end
    ld_col = IW'(load_count - CW'(ld_row) * CW'(n_cur));
  end

  assign in_acc  = element_valid && !element_stall;
  assign out_acc = result_valid && !result_stall;

  // Last pair of the last pivot.
  assign piv_last  = (l == nm1) && (IW'(k + 1'b1) == nm1);
  assign zero_pair = (opa == '0) && (ram_rdata == '0);
  assign quo_sat   = gqi_pkg::sat_quo(ures, acc[63] ^ dreg[31]);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      gqi_pkg::ST_LOAD: begin
        if (in_acc && element_last) state_next = gqi_pkg::ST_QINIT;
      end
      gqi_pkg::ST_QINIT: begin
        if (m == nm1 && l == nm1) begin
          state_next = (nm1 == '0) ? gqi_pkg::ST_BS_RDQ : gqi_pkg::ST_PV_RDX;
        end
      end
      gqi_pkg::ST_PV_RDX:  state_next = gqi_pkg::ST_PV_RDY;
      gqi_pkg::ST_PV_RDY:  state_next = gqi_pkg::ST_PV_LATY;
      gqi_pkg::ST_PV_LATY: begin
        if (zero_pair) begin
          state_next = piv_last ? gqi_pkg::ST_BS_RDQ : gqi_pkg::ST_PV_RDX;
        end else begin
          state_next = gqi_pkg::ST_PV_SQ1;
        end
      end
      gqi_pkg::ST_PV_SQ1:       state_next = gqi_pkg::ST_PV_SQ2;
      gqi_pkg::ST_PV_SQ2:       state_next = gqi_pkg::ST_PV_SQ3;
      gqi_pkg::ST_PV_SQ3:       state_next = gqi_pkg::ST_PV_SQRT_GO;
      gqi_pkg::ST_PV_SQRT_GO:   state_next = gqi_pkg::ST_PV_SQRT_WAIT;
      gqi_pkg::ST_PV_SQRT_WAIT: if (ustat.done) state_next = gqi_pkg::ST_PV_COS_GO;
      gqi_pkg::ST_PV_COS_GO:    state_next = gqi_pkg::ST_PV_COS_WAIT;
      gqi_pkg::ST_PV_COS_WAIT:  if (ustat.done) state_next = gqi_pkg::ST_PV_SIN_GO;
      gqi_pkg::ST_PV_SIN_GO:    state_next = gqi_pkg::ST_PV_SIN_WAIT;
      gqi_pkg::ST_PV_SIN_WAIT:  if (ustat.done) state_next = gqi_pkg::ST_PV_WRK;
      gqi_pkg::ST_PV_WRK:       state_next = gqi_pkg::ST_PV_WRL;
      gqi_pkg::ST_PV_WRL:       state_next = gqi_pkg::ST_RT_RDA;
      gqi_pkg::ST_RT_RDA:       state_next = gqi_pkg::ST_RT_RDB;
      gqi_pkg::ST_RT_RDB:       state_next = gqi_pkg::ST_RT_M1;
      gqi_pkg::ST_RT_M1:        state_next = gqi_pkg::ST_RT_M2;
      gqi_pkg::ST_RT_M2:        state_next = gqi_pkg::ST_RT_M3;
      gqi_pkg::ST_RT_M3:        state_next = gqi_pkg::ST_RT_M4;
      gqi_pkg::ST_RT_M4:        state_next = gqi_pkg::ST_RT_M5;
      gqi_pkg::ST_RT_M5:        state_next = gqi_pkg::ST_RT_M6;
      gqi_pkg::ST_RT_M6: begin
        if (m != nm1 || !sel) begin
          state_next = gqi_pkg::ST_RT_RDA;
        end else begin
          state_next = piv_last ? gqi_pkg::ST_BS_RDQ : gqi_pkg::ST_PV_RDX;
        end
      end
      gqi_pkg::ST_BS_RDQ:  state_next = gqi_pkg::ST_BS_RDD;
      gqi_pkg::ST_BS_RDD:  state_next = gqi_pkg::ST_BS_LATD;
      gqi_pkg::ST_BS_LATD: begin
        state_next = (ir == nm1) ? gqi_pkg::ST_BS_DIV_GO : gqi_pkg::ST_BS_RDL;
      end
      gqi_pkg::ST_BS_RDL: state_next = gqi_pkg::ST_BS_MUL;
      gqi_pkg::ST_BS_MUL: state_next = gqi_pkg::ST_BS_ACC;
      gqi_pkg::ST_BS_ACC: begin
        state_next = (m == nm1) ? gqi_pkg::ST_BS_DIV_GO : gqi_pkg::ST_BS_RDL;
      end
      gqi_pkg::ST_BS_DIV_GO: begin
        if (dreg == '0) begin
          state_next = (ir == '0) ? gqi_pkg::ST_EMIT : gqi_pkg::ST_BS_RDQ;
        end else begin
          state_next = gqi_pkg::ST_BS_DIV_WAIT;
        end
      end
      gqi_pkg::ST_BS_DIV_WAIT: begin
        if (ustat.done) state_next = (ir == '0) ? gqi_pkg::ST_EMIT : gqi_pkg::ST_BS_RDQ;
      end
      gqi_pkg::ST_EMIT: begin
        if (out_acc && l == nm1) begin
          state_next = (jr == nm1) ? gqi_pkg::ST_LOAD : gqi_pkg::ST_BS_RDQ;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    mul_a     = opa;
    mul_b     = opb;
    ureq      = '{start: 1'b0, op: gqi_pkg::OP_DIV};
    unum      = '0;
    uden      = '0;
    unique case (state)
      gqi_pkg::ST_LOAD: begin
        ram_we    = in_acc && (load_count < nn);
        ram_waddr = {1'b0, ld_row, ld_col};
        ram_wdata = element_value;
      end
      gqi_pkg::ST_QINIT: begin
        ram_we    = 1'b1;
        ram_waddr = {1'b1, m, l};
        ram_wdata = (m == l) ? Q_ONE : 32'd0;
      end
      gqi_pkg::ST_PV_RDX: ram_raddr = {1'b0, k, k};
      gqi_pkg::ST_PV_RDY: ram_raddr = {1'b0, k, l};
      gqi_pkg::ST_PV_SQ1: begin
        mul_a = opa;
        mul_b = opa;
      end
      gqi_pkg::ST_PV_SQ2: begin
        mul_a = opb;
        mul_b = opb;
      end
      gqi_pkg::ST_PV_SQRT_GO: begin
        ureq = '{start: 1'b1, op: gqi_pkg::OP_SQRT};
        unum = acc;
      end
      gqi_pkg::ST_PV_COS_GO: begin
        ureq = '{start: 1'b1, op: gqi_pkg::OP_DIV};
        unum = 64'(gqi_pkg::mag32(opa)) << gqi_pkg::ROT_BITS;
        uden = rr;
      end
      gqi_pkg::ST_PV_SIN_GO: begin
        ureq = '{start: 1'b1, op: gqi_pkg::OP_DIV};
        unum = 64'(gqi_pkg::mag32(opb)) << gqi_pkg::ROT_BITS;
        uden = rr;
      end
      gqi_pkg::ST_PV_WRK: begin
        ram_we    = 1'b1;
        ram_waddr = {1'b0, k, k};
        ram_wdata = rr[31] ? gqi_pkg::S32_MAX : rr;
      end
      gqi_pkg::ST_PV_WRL: begin
        ram_we    = 1'b1;
        ram_waddr = {1'b0, k, l};
      end
      gqi_pkg::ST_RT_RDA: ram_raddr = {sel, m, k};
      gqi_pkg::ST_RT_RDB: ram_raddr = {sel, m, l};
      gqi_pkg::ST_RT_M1: begin
        mul_a = cosr;
        mul_b = opa;
      end
      gqi_pkg::ST_RT_M2: begin
        mul_a = sinr;
        mul_b = opb;
      end
      gqi_pkg::ST_RT_M3: begin
        mul_a = sinr;
        mul_b = opa;
      end
      gqi_pkg::ST_RT_M4: begin
        mul_a     = cosr;
        mul_b     = opb;
        ram_we    = 1'b1;
        ram_waddr = {sel, m, k};
        ram_wdata = gqi_pkg::rnd_sat30(acc);
      end
      gqi_pkg::ST_RT_M6: begin
        ram_we    = 1'b1;
        ram_waddr = {sel, m, l};
        ram_wdata = gqi_pkg::rnd_sat30(acc);
      end
      gqi_pkg::ST_BS_RDQ: ram_raddr = {1'b1, jr, ir};
      gqi_pkg::ST_BS_RDD: ram_raddr = {1'b0, ir, ir};
      gqi_pkg::ST_BS_RDL: ram_raddr = {1'b0, m, ir};
      gqi_pkg::ST_BS_MUL: begin
        mul_a = ram_rdata;
        mul_b = xrow[m];
      end
      gqi_pkg::ST_BS_DIV_GO: begin
        ureq = '{start: (dreg != '0), op: gqi_pkg::OP_DIV};
        unum = gqi_pkg::mag64(acc);
        uden = gqi_pkg::mag32(dreg);
      end
      default: begin
      end
    endcase
  end

  assign element_stall = (state != gqi_pkg::ST_LOAD);
  assign result_valid  = (state == gqi_pkg::ST_EMIT);
  assign inverse_value = xrow[l];
  assign result_last   = (jr == nm1) && (l == nm1);
  assign singular      = singular_seen;
  assign saturated     = clip[l];

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gqi_pkg::ST_LOAD;
      matrix_size   <= SW'(8);
      load_count    <= '0;
      singular_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) matrix_size <= pwdata[SW-1:0];
      if (state == gqi_pkg::ST_LOAD && in_acc) begin
        if (element_last) begin
          load_count    <= '0;
          singular_seen <= 1'b0;
        end else if (load_count < nn) begin
          load_count <= load_count + 1'b1;
        end
      end
      if (state == gqi_pkg::ST_BS_DIV_GO && dreg == '0) singular_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      gqi_pkg::ST_LOAD: begin
        if (in_acc && element_last) begin
          nm1 <= IW'(n_cur - 1'b1);
          m   <= '0;
          l   <= '0;
        end
      end
      gqi_pkg::ST_QINIT: begin
        if (l == nm1) begin
          l <= '0;
          m <= m + 1'b1;
        end else begin
          l <= l + 1'b1;
        end
        if (m == nm1 && l == nm1) begin
          k  <= '0;
          l  <= IW'(1);
          jr <= '0;
          ir <= nm1;
        end
      end
      gqi_pkg::ST_PV_RDY: opa <= ram_rdata;
      gqi_pkg::ST_PV_LATY: begin
        opb <= ram_rdata;
        if (zero_pair) begin
          // zero pair: identity rotation, nothing to rotate
          cosr <= gqi_pkg::ROT_ONE;
          sinr <= '0;
          if (l == nm1) begin
            k <= k + 1'b1;
            l <= IW'(k + 2'd2);
          end else begin
            l <= l + 1'b1;
          end
        end
      end
      gqi_pkg::ST_PV_SQ2: acc <= prod;
      gqi_pkg::ST_PV_SQ3: acc <= acc + prod;
      gqi_pkg::ST_PV_SQRT_WAIT: if (ustat.done) rr <= ures[31:0];
      gqi_pkg::ST_PV_COS_WAIT: begin
        if (ustat.done) cosr <= opa[31] ? 32'(-ures[31:0]) : ures[31:0];
      end
      gqi_pkg::ST_PV_SIN_WAIT: begin
        if (ustat.done) sinr <= opb[31] ? ures[31:0] : 32'(-ures[31:0]);
      end
      gqi_pkg::ST_PV_WRL: begin
        sel <= 1'b0;
        m   <= k + 1'b1;
      end
      gqi_pkg::ST_RT_RDB: opa <= ram_rdata;
      gqi_pkg::ST_RT_M1:  opb <= ram_rdata;
      gqi_pkg::ST_RT_M2:  acc <= prod;
      gqi_pkg::ST_RT_M3:  acc <= acc - prod;
      gqi_pkg::ST_RT_M4:  acc <= prod;
      gqi_pkg::ST_RT_M5:  acc <= acc + prod;
      gqi_pkg::ST_RT_M6: begin
        if (m != nm1) begin
          m <= m + 1'b1;
        end else if (!sel) begin
          // W rows below the pivot are done; sweep all rows of Q
          sel <= 1'b1;
          m   <= '0;
        end else if (l == nm1) begin
          k <= k + 1'b1;
          l <= IW'(k + 2'd2);
        end else begin
          l <= l + 1'b1;
        end
      end
      gqi_pkg::ST_BS_RDD: acc <= 64'($signed(ram_rdata)) <<< FRAC_BITS;
      gqi_pkg::ST_BS_LATD: begin
        dreg <= ram_rdata;
        m    <= IW'(ir + 1'b1);
      end
      gqi_pkg::ST_BS_ACC: begin
        acc <= gqi_pkg::sat_sub64(acc, prod);
        m   <= m + 1'b1;
      end
      gqi_pkg::ST_BS_DIV_GO: begin
        if (dreg == '0) begin
          xrow[ir] <= '0;
          clip[ir] <= 1'b0;
          if (ir == '0) l <= '0;
          else          ir <= ir - 1'b1;
        end
      end
      gqi_pkg::ST_BS_DIV_WAIT: begin
        if (ustat.done) begin
          xrow[ir] <= quo_sat[31:0];
          clip[ir] <= quo_sat[32];
          if (ir == '0) l <= '0;
          else          ir <= ir - 1'b1;
        end
      end
      gqi_pkg::ST_EMIT: begin
        if (out_acc) begin
          if (l == nm1) begin
            jr <= jr + 1'b1;
            ir <= nm1;
            l  <= '0;
          end else begin
            l <= l + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  gqi_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gqi_divsqrt u_unit (
    .clk   (clk),
    .rst   (rst),
    .req   (ureq),
    .num   (unum),
    .den   (uden),
    .stat  (ustat),
    .result(ures)
  );

  // ---------------------------------------------------------------- checks
  `GQI_ASSERT_NOW(a_load_not_emit, !element_stall, !result_valid)
  `GQI_ASSERT_NOW(a_unit_free_on_start, ureq.start, !ustat.busy)
  `GQI_ASSERT_NEXT(a_back_to_load, out_acc && result_last, !element_stall)
  `GQI_ASSERT_NOW(a_no_write_in_emit, ram_we, !result_valid)

endmodule
`default_nettype wire
